### rtl/length_prefixed_message_deframer_top_defines.svh
// Assertion macros for the message deframer.
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define LPMD_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("deframer check failed");
// Next-cycle implication, checked out of reset.
`define LPMD_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("deframer check failed");
`else
`define LPMD_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define LPMD_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

### rtl/lpmd_pkg.sv
package lpmd_pkg;

  // Widths fixed by the stream format
  localparam int BYTE_W          = 8;
  localparam int MSG_LEN_W       = 32;
  localparam int LENGTH_BITS_DEF = 32;
  localparam int OUT_TDATA_W     = 48;

  // Input beat selector (tuser)
  typedef enum logic {
    MODE_FRAME_START = 1'b0,
    MODE_DATA        = 1'b1
  } mode_t;

  // Result kind (out tuser)
  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_BEGIN   = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_NONE      = 2'd0,
    CAUSE_BAD_FLAGS = 2'd1,
    CAUSE_BAD_COMP  = 2'd2,
    CAUSE_STICKY    = 2'd3
  } cause_t;

  // Header walk: compressed flag, four length bytes (MSB first), payload
  typedef enum logic [2:0] {
    PH_FLAG    = 3'd0,
    PH_LEN3    = 3'd1,
    PH_LEN2    = 3'd2,
    PH_LEN1    = 3'd3,
    PH_LEN0    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  typedef struct packed {
    mode_t               mode;
    logic [BYTE_W-1:0]   data_byte;
    logic                last_in_frame;
  } item_t;

  typedef struct packed {
    kind_t                kind;
    logic [MSG_LEN_W-1:0] message_length;
    logic                 compressed;
    logic [BYTE_W-1:0]    payload_byte;
    logic                 message_end;
    cause_t               error_cause;
    logic                 stream_closed;
  } result_t;

  typedef struct packed {
    logic failed;
    logic in_payload;
  } status_t;

endpackage

### rtl/lpmd_in_reg.sv
module lpmd_in_reg
  import lpmd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  s_valid,
  output logic  s_ready,
  input  item_t s_item,
  output logic  m_valid,
  input  logic  m_ready,
  output item_t m_item
);

  logic  valid_r;
  item_t item_r;

  // Take a new beat when empty or when the held one moves on
  assign s_ready = !valid_r || m_ready;
  assign m_valid = valid_r;
  assign m_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item_r <= s_item;
    end
  end

endmodule

### rtl/lpmd_walk.sv
module lpmd_walk
  import lpmd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  output result_t res,
  output status_t stat
);

  localparam logic [MSG_LEN_W-1:0] LEN_MAX =
    MSG_LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

  phase_t                  phase_r, phase_nxt;
  logic                    comp_r, comp_nxt;
  logic [23:0]             len_hi_r, len_hi_nxt;
  logic [LENGTH_BITS-1:0]  rem_r, rem_nxt;
  logic                    eos_r, eos_nxt;
  logic                    failed_r, failed_nxt;

  logic [MSG_LEN_W-1:0]    full_len;
  logic [MSG_LEN_W-1:0]    sat_len;
  logic                    flags_bad;
  logic                    comp_bad;
  logic                    rem_last;

  // Length assembly and saturation to the counter range
  assign full_len  = {len_hi_r, item.data_byte};
  assign sat_len   = (full_len > LEN_MAX) ? LEN_MAX : full_len;
  assign flags_bad = |item.data_byte[BYTE_W-1:1];
  assign comp_bad  = |item.data_byte[BYTE_W-1:1];
  assign rem_last  = (rem_r == LENGTH_BITS'(1));

  assign stat.failed     = failed_r;
  assign stat.in_payload = (phase_r == PH_PAYLOAD);

  // Next state
  always_comb begin
    phase_nxt  = phase_r;
    comp_nxt   = comp_r;
    len_hi_nxt = len_hi_r;
    rem_nxt    = rem_r;
    eos_nxt    = eos_r;
    failed_nxt = failed_r;
    if (fire && !failed_r) begin
      if (item.mode == MODE_FRAME_START) begin
        if (flags_bad) begin
          failed_nxt = 1'b1;
        end else begin
          eos_nxt = item.data_byte[0];
        end
      end else begin
        case (phase_r)
          PH_LEN3: begin
            len_hi_nxt = {16'd0, item.data_byte};
            phase_nxt  = PH_LEN2;
          end
          PH_LEN2: begin
            len_hi_nxt = {len_hi_r[15:0], item.data_byte};
            phase_nxt  = PH_LEN1;
          end
          PH_LEN1: begin
            len_hi_nxt = {len_hi_r[15:0], item.data_byte};
            phase_nxt  = PH_LEN0;
          end
          PH_LEN0: begin
            rem_nxt   = sat_len[LENGTH_BITS-1:0];
            phase_nxt = (sat_len == '0) ? PH_FLAG : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            rem_nxt = rem_r - LENGTH_BITS'(1);
            if (rem_last) begin
              phase_nxt = PH_FLAG;
            end
          end
          default: begin
            // compressed-flag byte; unused codes behave the same
            if (comp_bad) begin
              failed_nxt = 1'b1;
            end else begin
              comp_nxt  = item.data_byte[0];
              phase_nxt = PH_LEN3;
            end
          end
        endcase
      end
    end
  end

  // Result for the beat in the input register
  always_comb begin
    res = '0;
    if (failed_r) begin
      res.kind        = KIND_ERROR;
      res.error_cause = CAUSE_STICKY;
    end else if (item.mode == MODE_FRAME_START) begin
      if (flags_bad) begin
        res.kind        = KIND_ERROR;
        res.error_cause = CAUSE_BAD_FLAGS;
      end else begin
        res.stream_closed = item.last_in_frame && item.data_byte[0];
      end
    end else begin
      res.stream_closed = item.last_in_frame && eos_r;
      case (phase_r)
        PH_LEN3, PH_LEN2, PH_LEN1: begin
          res.kind = KIND_NONE;
        end
        PH_LEN0: begin
          res.kind           = KIND_BEGIN;
          res.message_length = sat_len;
          res.compressed     = comp_r;
          res.message_end    = (sat_len == '0);
        end
        PH_PAYLOAD: begin
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = item.data_byte;
          res.message_end  = rem_last;
        end
        default: begin
          if (comp_bad) begin
            res.kind        = KIND_ERROR;
            res.error_cause = CAUSE_BAD_COMP;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FLAG;
      comp_r   <= 1'b0;
      rem_r    <= '0;
      eos_r    <= 1'b0;
      failed_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      comp_r   <= comp_nxt;
      rem_r    <= rem_nxt;
      eos_r    <= eos_nxt;
      failed_r <= failed_nxt;
    end
  end

  // Upper length bytes: no reset, always rewritten before use
  always_ff @(posedge clk) begin
    len_hi_r <= len_hi_nxt;
  end

endmodule

### rtl/lpmd_out_reg.sv
module lpmd_out_reg
  import lpmd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    s_valid,
  output logic    s_ready,
  input  result_t s_res,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_res
);

  logic    valid_r;
  result_t res_r;

  // Load when empty or when the held result is taken this cycle
  assign s_ready = !valid_r || m_ready;
  assign m_valid = valid_r;
  assign m_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      res_r <= s_res;
    end
  end

endmodule

### rtl/length_prefixed_message_deframer_top.sv
// Channel | Dir | tdata                 | tuser | tlast
// in_     | in  | data_byte             | mode  | last_in_frame
// out_    | out | length/comp/byte/etc. | kind  | message_end
//
// One beat per cycle sustained while out_tready stays high.
// Input register, one step of header/payload logic, result register.
// rst_n clears the header walk, the error flag and both valid bits.
// A stall on out_tready holds the result and backs up into in_tready in the
// same cycle; no beat is dropped or repeated.
`include "length_prefixed_message_deframer_top_defines.svh"

module length_prefixed_message_deframer_top
  import lpmd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] mode
  input  logic                   in_tlast,   // last_in_frame
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] message_length, [32] compressed, [40:33] payload_byte,
  // [42:41] error_cause, [43] stream_closed, [47:44] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,  // [1:0] kind
  output logic                   out_tlast   // message_end
);

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    s2_ready;
  result_t step_res;
  result_t out_res;
  status_t stat;

  assign in_item.mode          = mode_t'(in_tuser);
  assign in_item.data_byte     = in_tdata;
  assign in_item.last_in_frame = in_tlast;

  lpmd_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_item  (in_item),
    .m_valid (s1_valid),
    .m_ready (s2_ready),
    .m_item  (s1_item)
  );

  lpmd_walk #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_valid && s2_ready),
    .item  (s1_item),
    .res   (step_res),
    .stat  (stat)
  );

  lpmd_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (s1_valid),
    .s_ready (s2_ready),
    .s_res   (step_res),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_res   (out_res)
  );

  // Pack result beat
  assign out_tdata = {4'd0, out_res.stream_closed, out_res.error_cause,
                      out_res.payload_byte, out_res.compressed,
                      out_res.message_length};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.message_end;

  // Error state never clears without reset
  `LPMD_ASSERT_NEXT(a_fail_sticky, clk, rst_n, stat.failed, stat.failed)
  // End marker only on a begin or a payload byte
  `LPMD_ASSERT_IMPLY(a_end_kind, clk, rst_n, out_tvalid && out_tlast,
    out_tuser == KIND_BEGIN || out_tuser == KIND_PAYLOAD)
  // Error results always carry a cause
  `LPMD_ASSERT_IMPLY(a_err_cause, clk, rst_n, out_tvalid && out_tuser == KIND_ERROR,
    out_tdata[42:41] != CAUSE_NONE)
  // Once failed, every beat leaving the walk is an error
  `LPMD_ASSERT_IMPLY(a_fail_out, clk, rst_n, stat.failed && s1_valid,
    step_res.kind == KIND_ERROR)
  // Payload bytes only come out of the payload phase
  `LPMD_ASSERT_IMPLY(a_pay_phase, clk, rst_n, s1_valid && step_res.kind == KIND_PAYLOAD,
    stat.in_payload)

endmodule

### sim/length_prefixed_message_deframer_checker.sv
module length_prefixed_message_deframer_checker
  import lpmd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] mode
  input  logic                   in_tlast,   // last_in_frame
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] message_length, [32] compressed, [40:33] payload_byte,
  // [42:41] error_cause, [43] stream_closed, [47:44] zero
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [1:0]             out_tuser,  // [1:0] kind
  input  logic                   out_tlast,  // message_end
  output int                     fail_count,
  output int                     pending
);

  localparam logic [MSG_LEN_W:0] LEN_CAP_WIDE = (33'd1 << LENGTH_BITS_DEF) - 33'd1;
  localparam logic [MSG_LEN_W-1:0] LEN_CAP = LEN_CAP_WIDE[MSG_LEN_W-1:0];
  localparam int PRINT_CAP = 40;

  // Predicted deframer state
  phase_t               walk_phase;
  logic                 comp_flag;
  logic [MSG_LEN_W-1:0] msg_left;
  logic                 eos_seen;
  logic                 failed;

  result_t expected_results [$];
  int      beat_no;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < PRINT_CAP)
      $display("MISMATCH out beat %0d, %s: got 0x%0h, want 0x%0h", beat_no, what, got, want);
    fail_count++;
  endtask

  // One input beat through the deframer; returns the result it causes
  function automatic result_t deframe_step(input mode_t mode, input logic [7:0] b,
                                           input logic last);
    result_t r;
    r = '0;
    if (failed) begin
      r.kind        = KIND_ERROR;
      r.error_cause = CAUSE_STICKY;
    end else if (mode == MODE_FRAME_START) begin
      if (b[7:1] != 7'd0) begin
        r.kind        = KIND_ERROR;
        r.error_cause = CAUSE_BAD_FLAGS;
        failed        = 1'b1;
      end else begin
        eos_seen        = b[0];
        r.stream_closed = last & eos_seen;
      end
    end else begin
      r.stream_closed = last & eos_seen;
      case (walk_phase)
        PH_LEN3: begin
          msg_left   = {b, 24'd0};
          walk_phase = PH_LEN2;
        end
        PH_LEN2: begin
          msg_left[23:16] = b;
          walk_phase      = PH_LEN1;
        end
        PH_LEN1: begin
          msg_left[15:8] = b;
          walk_phase     = PH_LEN0;
        end
        PH_LEN0: begin
          msg_left[7:0] = b;
          if (msg_left > LEN_CAP) msg_left = LEN_CAP;
          r.kind           = KIND_BEGIN;
          r.message_length = msg_left;
          r.compressed     = comp_flag;
          if (msg_left == '0) begin
            r.message_end = 1'b1;
            walk_phase    = PH_FLAG;
          end else begin
            walk_phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          r.kind         = KIND_PAYLOAD;
          r.payload_byte = b;
          msg_left       = msg_left - 32'd1;
          if (msg_left == '0) begin
            r.message_end = 1'b1;
            walk_phase    = PH_FLAG;
          end
        end
        default: begin
          // compressed flag byte
          if (b <= 8'd1) begin
            comp_flag  = b[0];
            walk_phase = PH_LEN3;
          end else begin
            r.kind        = KIND_ERROR;
            r.error_cause = CAUSE_BAD_COMP;
            failed        = 1'b1;
          end
        end
      endcase
    end
    return r;
  endfunction

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      walk_phase = PH_FLAG;
      comp_flag  = 1'b0;
      msg_left   = '0;
      eos_seen   = 1'b0;
      failed     = 1'b0;
      beat_no    = 0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(deframe_step(mode_t'(in_tuser), in_tdata, in_tlast));
      if (out_tvalid && out_tready) begin
        beat_no++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", {30'd0, out_tuser}, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch("kind", {30'd0, out_tuser}, {30'd0, want.kind});
          if (out_tdata[31:0] !== want.message_length)
            report_mismatch("message_length", out_tdata[31:0], want.message_length);
          if (out_tdata[32] !== want.compressed)
            report_mismatch("compressed", {31'd0, out_tdata[32]}, {31'd0, want.compressed});
          if (out_tdata[40:33] !== want.payload_byte)
            report_mismatch("payload_byte", {24'd0, out_tdata[40:33]},
                            {24'd0, want.payload_byte});
          if (out_tlast !== want.message_end)
            report_mismatch("message_end", {31'd0, out_tlast}, {31'd0, want.message_end});
          if (out_tdata[42:41] !== want.error_cause)
            report_mismatch("error_cause", {30'd0, out_tdata[42:41]},
                            {30'd0, want.error_cause});
          if (out_tdata[43] !== want.stream_closed)
            report_mismatch("stream_closed", {31'd0, out_tdata[43]},
                            {31'd0, want.stream_closed});
          if (out_tdata[OUT_TDATA_W-1:44] !== '0)
            report_mismatch("tdata padding", {28'd0, out_tdata[OUT_TDATA_W-1:44]}, 32'd0);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

### sim/length_prefixed_message_deframer_top_tb.sv
module length_prefixed_message_deframer_top_tb;
  import lpmd_pkg::*;

  localparam int RANDOM_ITEMS = 1220;
  localparam int DRAIN_CYCLES = 10;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;

  int mismatches;
  int results_owed;

  // Sender burst control
  int burst_left = 0;
  bit idle_en = 1'b0;
  int sent_items = 0;

  // Receiver stall pattern
  logic [15:0] ready_pattern = 16'hFFFF;
  int          rx_cycle = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  length_prefixed_message_deframer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  length_prefixed_message_deframer_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (mismatches),
    .pending    (results_owed)
  );

  // Receiver: random stall pattern, sometimes no stalls at all
  always @(negedge clk) begin
    if (rx_cycle % 64 == 0)
      ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
    out_tready = ready_pattern[4'(rx_cycle % 16)];
    rx_cycle++;
  end

  // One input beat; called and returns at a falling edge
  task automatic send_item(input mode_t mode, input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = idle_en ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = b;
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  // Stream byte, with a frame break slipped in now and then
  task automatic send_stream_byte(input logic [7:0] b);
    if ($urandom_range(0, 9) == 0)
      send_item(MODE_FRAME_START, {7'd0, 1'($urandom_range(0, 1))},
                $urandom_range(0, 5) == 0);
    send_item(MODE_DATA, b, $urandom_range(0, 7) == 0);
  endtask

  // Header plus body_bytes payload bytes of random content
  task automatic send_message(input logic comp, input logic [31:0] len,
                              input int unsigned body_bytes);
    send_stream_byte({7'd0, comp});
    for (int i = 3; i >= 0; i--) send_stream_byte(len[8*i +: 8]);
    for (int unsigned i = 0; i < body_bytes; i++) send_stream_byte(8'($urandom));
  endtask

  initial begin
    int unsigned pick;
    int unsigned len;
    logic        comp;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero length, two-byte compressed message, empty closing frame,
    // stream close on a payload byte
    send_item(MODE_FRAME_START, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'h01, 1'b0);
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'h02, 1'b0);
    send_item(MODE_DATA, 8'hFF, 1'b0);
    send_item(MODE_DATA, 8'h00, 1'b1);
    send_item(MODE_FRAME_START, 8'h01, 1'b1);
    send_item(MODE_FRAME_START, 8'h01, 1'b0);
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'h01, 1'b0);
    send_item(MODE_DATA, 8'hA5, 1'b1);

    // Random well-formed messages, mostly short, rarely a few hundred bytes
    while (sent_items < RANDOM_ITEMS) begin
      idle_en = ($urandom_range(0, 7) != 0);
      pick = $urandom_range(0, 59);
      if (pick < 3)       len = 0;
      else if (pick < 50) len = $urandom_range(1, 12);
      else if (pick < 59) len = $urandom_range(13, 40);
      else                len = $urandom_range(256, 600);
      comp = 1'($urandom_range(0, 1));
      send_message(comp, len, len);
    end

    // Close out with one error; it is sticky, so only one cause per run
    idle_en = 1'b1;
    if ($urandom_range(0, 1) == 0) begin
      // maximum declared length, partial body, then bad frame flags
      send_message(1'($urandom_range(0, 1)), 32'hFFFF_FFFF, 30);
      send_item(MODE_FRAME_START, {7'($urandom_range(1, 127)), 1'($urandom_range(0, 1))},
                1'($urandom_range(0, 1)));
    end else begin
      send_item(MODE_DATA, 8'($urandom_range(2, 255)), 1'($urandom_range(0, 1)));
    end

    // Everything after the error must come back as sticky errors
    repeat (40)
      send_item(mode_t'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
    in_tvalid = 1'b0;

    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### length_prefixed_message_deframer_top.f
+incdir+rtl
rtl/lpmd_pkg.sv
rtl/lpmd_in_reg.sv
rtl/lpmd_walk.sv
rtl/lpmd_out_reg.sv
rtl/length_prefixed_message_deframer_top.sv
sim/length_prefixed_message_deframer_checker.sv
sim/length_prefixed_message_deframer_top_tb.sv
